>>> rtl/core/kf2s_pkg.sv
// Package with types, constants and the step microprogram of the two-state Kalman filter core.
`timescale 1ns / 1ps
package kf2s_pkg;

  localparam int STATE_DIM_DEF = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int VAL_W = 41;
  localparam int ACC_W = 64;
  localparam int PROD_W = 72;
  localparam int DIV_W = 56;
  localparam int DIV_CNT_W = 6;
  localparam int PC_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_TRANSITION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PNOISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MROW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MNOISE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_STATE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV = 3'd6;

  localparam logic [PC_W-1:0] PC_INNOV = 6'd29;
  localparam logic [PC_W-1:0] PC_CORR = 6'd30;
  localparam logic [PC_W-1:0] PC_LAST = 6'd49;

  localparam logic signed [ACC_W-1:0] MAX32 = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] MIN32 = -64'sd2147483648;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_END,
    ST_FINISH
  } state_t;

  typedef enum logic [4:0] {
    S_ZERO, S_X0, S_X1, S_P0, S_P1, S_P2, S_P3, S_T0, S_T1, S_T2, S_T3,
    S_PH0, S_PH1, S_K0, S_K1, S_M0, S_M1, S_M2, S_M3, S_U, S_Y,
    S_A0, S_A1, S_A2, S_A3, S_B0, S_B1, S_H0, S_H1, S_ONE
  } src_t;

  typedef enum logic [4:0] {
    D_NONE, D_X0, D_X1, D_P0, D_P1, D_P2, D_P3, D_T0, D_T1, D_T2, D_T3,
    D_PH0, D_PH1, D_M0, D_M1, D_M2, D_M3, D_Y, D_S
  } dst_t;

  typedef enum logic [3:0] {
    I_ZERO, I_Q0, I_Q1, I_Q2, I_Q3, I_R, I_Z, I_ONE, I_X0, I_X1
  } init_t;

  typedef struct packed {
    src_t  sa;
    src_t  sb;
    logic  sh16;
    logic  first;
    init_t init;
    logic  neg;
    logic  last;
    dst_t  dst;
    logic  clip;
  } uop_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } clip_t;

  function automatic clip_t clip32(input logic signed [ACC_W-1:0] v);
    clip_t r;
    if (v > MAX32) begin
      r.val = MAX32[31:0];
      r.sat = 1'b1;
    end else if (v < MIN32) begin
      r.val = MIN32[31:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] coef(input logic [63:0] w, input logic [1:0] pos);
    return $signed(w[pos*16 +: 16]);
  endfunction

  function automatic uop_t mk(input src_t sa, input src_t sb, input logic sh16,
                              input logic first, input init_t init, input logic neg,
                              input logic last, input dst_t dst, input logic clip);
    uop_t u;
    u.sa = sa;
    u.sb = sb;
    u.sh16 = sh16;
    u.first = first;
    u.init = init;
    u.neg = neg;
    u.last = last;
    u.dst = dst;
    u.clip = clip;
    return u;
  endfunction

  // Each entry is one rounded product added to or subtracted from the accumulator.
  function automatic uop_t uop(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(S_U,   S_B0,  1'b0, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd1:  u = mk(S_X0,  S_A0,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd2:  u = mk(S_X1,  S_A1,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_M0,   1'b1);
      6'd3:  u = mk(S_U,   S_B1,  1'b0, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd4:  u = mk(S_X0,  S_A2,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd5:  u = mk(S_X1,  S_A3,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_M1,   1'b1);
      6'd6:  u = mk(S_M0,  S_ONE, 1'b0, 1'b1, I_ZERO, 1'b0, 1'b1, D_X0,   1'b0);
      6'd7:  u = mk(S_M1,  S_ONE, 1'b0, 1'b1, I_ZERO, 1'b0, 1'b1, D_X1,   1'b0);
      6'd8:  u = mk(S_P0,  S_A0,  1'b0, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd9:  u = mk(S_P2,  S_A1,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_T0,   1'b0);
      6'd10: u = mk(S_P1,  S_A0,  1'b0, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd11: u = mk(S_P3,  S_A1,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_T1,   1'b0);
      6'd12: u = mk(S_P0,  S_A2,  1'b0, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd13: u = mk(S_P2,  S_A3,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_T2,   1'b0);
      6'd14: u = mk(S_P1,  S_A2,  1'b0, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd15: u = mk(S_P3,  S_A3,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_T3,   1'b0);
      6'd16: u = mk(S_T0,  S_A0,  1'b0, 1'b1, I_Q0,   1'b0, 1'b0, D_NONE, 1'b0);
      6'd17: u = mk(S_T1,  S_A1,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_P0,   1'b1);
      6'd18: u = mk(S_T0,  S_A2,  1'b0, 1'b1, I_Q1,   1'b0, 1'b0, D_NONE, 1'b0);
      6'd19: u = mk(S_T1,  S_A3,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_P1,   1'b1);
      6'd20: u = mk(S_T2,  S_A0,  1'b0, 1'b1, I_Q2,   1'b0, 1'b0, D_NONE, 1'b0);
      6'd21: u = mk(S_T3,  S_A1,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_P2,   1'b1);
      6'd22: u = mk(S_T2,  S_A2,  1'b0, 1'b1, I_Q3,   1'b0, 1'b0, D_NONE, 1'b0);
      6'd23: u = mk(S_T3,  S_A3,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_P3,   1'b1);
      6'd24: u = mk(S_P0,  S_H0,  1'b0, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd25: u = mk(S_P1,  S_H1,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_PH0,  1'b0);
      6'd26: u = mk(S_P2,  S_H0,  1'b0, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd27: u = mk(S_P3,  S_H1,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_PH1,  1'b0);
      6'd28: u = mk(S_PH0, S_H0,  1'b0, 1'b1, I_R,    1'b0, 1'b0, D_NONE, 1'b0);
      6'd29: u = mk(S_PH1, S_H1,  1'b0, 1'b0, I_ZERO, 1'b0, 1'b1, D_S,    1'b0);
      6'd30: u = mk(S_X0,  S_H0,  1'b0, 1'b1, I_Z,    1'b1, 1'b0, D_NONE, 1'b0);
      6'd31: u = mk(S_X1,  S_H1,  1'b0, 1'b0, I_ZERO, 1'b1, 1'b1, D_Y,    1'b1);
      6'd32: u = mk(S_K0,  S_Y,   1'b1, 1'b1, I_X0,   1'b0, 1'b1, D_X0,   1'b1);
      6'd33: u = mk(S_K1,  S_Y,   1'b1, 1'b1, I_X1,   1'b0, 1'b1, D_X1,   1'b1);
      6'd34: u = mk(S_K0,  S_H0,  1'b0, 1'b1, I_ONE,  1'b1, 1'b1, D_M0,   1'b1);
      6'd35: u = mk(S_K0,  S_H1,  1'b0, 1'b1, I_ZERO, 1'b1, 1'b1, D_M1,   1'b1);
      6'd36: u = mk(S_K1,  S_H0,  1'b0, 1'b1, I_ZERO, 1'b1, 1'b1, D_M2,   1'b1);
      6'd37: u = mk(S_K1,  S_H1,  1'b0, 1'b1, I_ONE,  1'b1, 1'b1, D_M3,   1'b1);
      6'd38: u = mk(S_M0,  S_P0,  1'b1, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd39: u = mk(S_M1,  S_P2,  1'b1, 1'b0, I_ZERO, 1'b0, 1'b1, D_T0,   1'b1);
      6'd40: u = mk(S_M0,  S_P1,  1'b1, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd41: u = mk(S_M1,  S_P3,  1'b1, 1'b0, I_ZERO, 1'b0, 1'b1, D_T1,   1'b1);
      6'd42: u = mk(S_M2,  S_P0,  1'b1, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd43: u = mk(S_M3,  S_P2,  1'b1, 1'b0, I_ZERO, 1'b0, 1'b1, D_T2,   1'b1);
      6'd44: u = mk(S_M2,  S_P1,  1'b1, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
      6'd45: u = mk(S_M3,  S_P3,  1'b1, 1'b0, I_ZERO, 1'b0, 1'b1, D_T3,   1'b1);
      6'd46: u = mk(S_T0,  S_ONE, 1'b0, 1'b1, I_ZERO, 1'b0, 1'b1, D_P0,   1'b0);
      6'd47: u = mk(S_T1,  S_ONE, 1'b0, 1'b1, I_ZERO, 1'b0, 1'b1, D_P1,   1'b0);
      6'd48: u = mk(S_T2,  S_ONE, 1'b0, 1'b1, I_ZERO, 1'b0, 1'b1, D_P2,   1'b0);
      6'd49: u = mk(S_T3,  S_ONE, 1'b0, 1'b1, I_ZERO, 1'b0, 1'b1, D_P3,   1'b0);
      default: u = mk(S_ZERO, S_ZERO, 1'b0, 1'b1, I_ZERO, 1'b0, 1'b0, D_NONE, 1'b0);
    endcase
    return u;
  endfunction

endpackage

>>> rtl/core/kalman_filter_two_state_core.sv
// Top level of the two-state Kalman filter core: sequencer, shared multiplier and divider.
`timescale 1ns / 1ps
// Each measurement transfer runs a fixed microprogram on one shared 41 x 32 bit multiplier
// with a 64-bit accumulator, a multiply state and an accumulate state per product, and
// forms the two gain entries with a restoring divider that retires one quotient bit per
// cycle. A step with correction runs the whole microprogram (after a load state with
// reload) and the core takes the next transfer once the result is in the output register;
// a step whose innovation variance is not positive stops after prediction. The core takes
// no new transfer while a step runs, but a finished result may wait in the output register
// while the next step is computed.
module kalman_filter_two_state_core #(
  parameter int STATE_DIM = kf2s_pkg::STATE_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [31:0]                  in_measurement,
  input  logic signed [31:0]                  in_control,
  input  logic                                in_reload,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  out_estimate_first,
  output logic signed [31:0]                  out_estimate_second,
  output logic                                out_no_correction,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kf2s_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kf2s_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import kf2s_pkg::*;

  localparam bit ONE_DIM = (STATE_DIM == 1);

  state_t state_r, state_nxt;

  logic [63:0] a_r, q_r, p0_r;
  logic [31:0] b_r, h_r, x0init_r;
  logic [15:0] r_r;

  logic signed [31:0] x_r [2];
  logic signed [31:0] p_r [4];
  logic signed [VAL_W-1:0] t_r [4];
  logic signed [VAL_W-1:0] ph_r [2];
  logic signed [31:0] k_r [2];
  logic signed [31:0] m_r [4];
  logic signed [31:0] y_r, z_r, u_r;
  logic signed [ACC_W-1:0] s_r, acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [PC_W-1:0] pc_r;
  logic sat_r, skip_r;
  logic [DIV_W-1:0] div_num_r;
  logic [ACC_W-1:0] rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic div_sel_r, div_neg_r;
  logic out_valid_r, out_nc_r, out_sat_r;
  logic signed [31:0] out_e0_r, out_e1_r;

  uop_t cur;
  logic signed [VAL_W-1:0] opa;
  logic signed [31:0] opb;
  logic signed [ACC_W-1:0] init_val, acc_base, term, acc_sum, wval;
  logic signed [PROD_W-1:0] rsum, rnd;
  clip_t acc_cl, div_cl;
  logic dst_ok, finish_fire;
  logic [ACC_W-1:0] rem_sh;
  logic div_ge;
  logic signed [VAL_W-1:0] div_src, div_mag;
  logic signed [ACC_W-1:0] div_q;

  assign cur = uop(pc_r);
  assign in_ready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_estimate_first = out_e0_r;
  assign out_estimate_second = out_e1_r;
  assign out_no_correction = out_nc_r;
  assign out_saturated = out_sat_r;
  assign finish_fire = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    case (cur.sa)
      S_X0:    opa = VAL_W'(x_r[0]);
      S_X1:    opa = ONE_DIM ? '0 : VAL_W'(x_r[1]);
      S_P0:    opa = VAL_W'(p_r[0]);
      S_P1:    opa = ONE_DIM ? '0 : VAL_W'(p_r[1]);
      S_P2:    opa = ONE_DIM ? '0 : VAL_W'(p_r[2]);
      S_P3:    opa = ONE_DIM ? '0 : VAL_W'(p_r[3]);
      S_T0:    opa = t_r[0];
      S_T1:    opa = ONE_DIM ? '0 : t_r[1];
      S_T2:    opa = ONE_DIM ? '0 : t_r[2];
      S_T3:    opa = ONE_DIM ? '0 : t_r[3];
      S_PH0:   opa = ph_r[0];
      S_PH1:   opa = ONE_DIM ? '0 : ph_r[1];
      S_K0:    opa = VAL_W'(k_r[0]);
      S_K1:    opa = ONE_DIM ? '0 : VAL_W'(k_r[1]);
      S_M0:    opa = VAL_W'(m_r[0]);
      S_M1:    opa = ONE_DIM ? '0 : VAL_W'(m_r[1]);
      S_M2:    opa = ONE_DIM ? '0 : VAL_W'(m_r[2]);
      S_M3:    opa = ONE_DIM ? '0 : VAL_W'(m_r[3]);
      S_U:     opa = VAL_W'(u_r);
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (cur.sb)
      S_P0:    opb = p_r[0];
      S_P1:    opb = ONE_DIM ? '0 : p_r[1];
      S_P2:    opb = ONE_DIM ? '0 : p_r[2];
      S_P3:    opb = ONE_DIM ? '0 : p_r[3];
      S_Y:     opb = y_r;
      S_A0:    opb = 32'(coef(a_r, 2'd0));
      S_A1:    opb = ONE_DIM ? '0 : 32'(coef(a_r, 2'd1));
      S_A2:    opb = ONE_DIM ? '0 : 32'(coef(a_r, 2'd2));
      S_A3:    opb = ONE_DIM ? '0 : 32'(coef(a_r, 2'd3));
      S_B0:    opb = 32'(coef({32'b0, b_r}, 2'd0));
      S_B1:    opb = ONE_DIM ? '0 : 32'(coef({32'b0, b_r}, 2'd1));
      S_H0:    opb = 32'(coef({32'b0, h_r}, 2'd0));
      S_H1:    opb = ONE_DIM ? '0 : 32'(coef({32'b0, h_r}, 2'd1));
      S_ONE:   opb = 32'sd256;
      default: opb = '0;
    endcase
  end

  always_comb begin
    case (cur.init)
      I_Q0:    init_val = ACC_W'($signed({coef(q_r, 2'd0), 8'b0}));
      I_Q1:    init_val = ONE_DIM ? '0 : ACC_W'($signed({coef(q_r, 2'd1), 8'b0}));
      I_Q2:    init_val = ONE_DIM ? '0 : ACC_W'($signed({coef(q_r, 2'd2), 8'b0}));
      I_Q3:    init_val = ONE_DIM ? '0 : ACC_W'($signed({coef(q_r, 2'd3), 8'b0}));
      I_R:     init_val = {40'b0, r_r, 8'b0};
      I_Z:     init_val = ACC_W'(z_r);
      I_ONE:   init_val = 64'sd65536;
      I_X0:    init_val = ACC_W'(x_r[0]);
      I_X1:    init_val = ONE_DIM ? '0 : ACC_W'(x_r[1]);
      default: init_val = '0;
    endcase
  end

  always_comb begin
    rsum = prod_r + (cur.sh16 ? 72'sd32768 : 72'sd128);
    rnd = cur.sh16 ? (rsum >>> 16) : (rsum >>> 8);
    term = $signed(rnd[ACC_W-1:0]);
    acc_base = cur.first ? init_val : acc_r;
    acc_sum = cur.neg ? (acc_base - term) : (acc_base + term);
    acc_cl = clip32(acc_sum);
    wval = cur.clip ? ACC_W'(acc_cl.val) : acc_sum;
    case (cur.dst)
      D_X1, D_P1, D_P2, D_P3, D_T1, D_T2, D_T3, D_PH1, D_M1, D_M2, D_M3: dst_ok = !ONE_DIM;
      default: dst_ok = 1'b1;
    endcase
  end

  always_comb begin
    rem_sh = {rem_r[ACC_W-2:0], div_num_r[DIV_W-1]};
    div_ge = (rem_sh >= s_r);
    div_src = div_sel_r ? ph_r[1] : ph_r[0];
    div_mag = (div_src < 0) ? -div_src : div_src;
    div_q = div_neg_r ? -ACC_W'(div_num_r) : ACC_W'(div_num_r);
    div_cl = clip32(div_q);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = in_reload ? ST_LOAD : ST_MUL;
      ST_LOAD:     state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_ACC;
      ST_ACC: begin
        if (pc_r == PC_INNOV) begin
          state_nxt = (acc_sum <= 0) ? ST_FINISH : ST_DIV_INIT;
        end else if (pc_r == PC_LAST) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DIV_INIT: state_nxt = ST_DIV_STEP;
      ST_DIV_STEP: if (div_cnt_r == DIV_CNT_W'(DIV_W - 1)) state_nxt = ST_DIV_END;
      ST_DIV_END:  state_nxt = (div_sel_r || ONE_DIM) ? ST_MUL : ST_DIV_INIT;
      ST_FINISH:   if (finish_fire) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      pc_r <= '0;
      a_r <= 64'h0100000000000100;
      b_r <= '0;
      q_r <= '0;
      h_r <= 32'h100;
      r_r <= 16'h100;
      x0init_r <= '0;
      p0_r <= 64'h0100000000000100;
      x_r[0] <= '0;
      x_r[1] <= '0;
      p_r[0] <= 32'sd65536;
      p_r[1] <= '0;
      p_r[2] <= '0;
      p_r[3] <= ONE_DIM ? '0 : 32'sd65536;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TRANSITION: a_r <= cfg_data;
          REG_CONTROL:    b_r <= cfg_data[31:0];
          REG_PNOISE:     q_r <= cfg_data;
          REG_MROW:       h_r <= cfg_data[31:0];
          REG_MNOISE:     r_r <= cfg_data[15:0];
          REG_INIT_STATE: x0init_r <= cfg_data[31:0];
          REG_INIT_COV:   p0_r <= cfg_data;
          default: ;
        endcase
      end
      if (finish_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            z_r <= in_measurement;
            u_r <= in_control;
            sat_r <= 1'b0;
            skip_r <= 1'b0;
            pc_r <= '0;
          end
        end
        ST_LOAD: begin
          x_r[0] <= 32'($signed({coef({32'b0, x0init_r}, 2'd0), 8'b0}));
          x_r[1] <= ONE_DIM ? '0 : 32'($signed({coef({32'b0, x0init_r}, 2'd1), 8'b0}));
          p_r[0] <= 32'($signed({coef(p0_r, 2'd0), 8'b0}));
          p_r[1] <= ONE_DIM ? '0 : 32'($signed({coef(p0_r, 2'd1), 8'b0}));
          p_r[2] <= ONE_DIM ? '0 : 32'($signed({coef(p0_r, 2'd2), 8'b0}));
          p_r[3] <= ONE_DIM ? '0 : 32'($signed({coef(p0_r, 2'd3), 8'b0}));
        end
        ST_MUL: prod_r <= PROD_W'(opa) * PROD_W'(opb);
        ST_ACC: begin
          acc_r <= acc_sum;
          if (cur.last && dst_ok) begin
            if (cur.clip) sat_r <= sat_r | acc_cl.sat;
            case (cur.dst)
              D_X0:  x_r[0] <= wval[31:0];
              D_X1:  x_r[1] <= wval[31:0];
              D_P0:  p_r[0] <= wval[31:0];
              D_P1:  p_r[1] <= wval[31:0];
              D_P2:  p_r[2] <= wval[31:0];
              D_P3:  p_r[3] <= wval[31:0];
              D_T0:  t_r[0] <= wval[VAL_W-1:0];
              D_T1:  t_r[1] <= wval[VAL_W-1:0];
              D_T2:  t_r[2] <= wval[VAL_W-1:0];
              D_T3:  t_r[3] <= wval[VAL_W-1:0];
              D_PH0: ph_r[0] <= wval[VAL_W-1:0];
              D_PH1: ph_r[1] <= wval[VAL_W-1:0];
              D_M0:  m_r[0] <= wval[31:0];
              D_M1:  m_r[1] <= wval[31:0];
              D_M2:  m_r[2] <= wval[31:0];
              D_M3:  m_r[3] <= wval[31:0];
              D_Y:   y_r <= wval[31:0];
              D_S:   s_r <= acc_sum;
              default: ;
            endcase
          end
          if (pc_r == PC_INNOV) begin
            skip_r <= (acc_sum <= 0);
            div_sel_r <= 1'b0;
          end else begin
            pc_r <= pc_r + 1'b1;
          end
        end
        ST_DIV_INIT: begin
          div_neg_r <= (div_src < 0);
          div_num_r <= {div_mag[DIV_W-17:0], 16'b0};
          rem_r <= '0;
          div_cnt_r <= '0;
        end
        ST_DIV_STEP: begin
          rem_r <= div_ge ? (rem_sh - s_r) : rem_sh;
          div_num_r <= {div_num_r[DIV_W-2:0], div_ge};
          div_cnt_r <= div_cnt_r + 1'b1;
        end
        ST_DIV_END: begin
          if (div_sel_r) k_r[1] <= div_cl.val;
          else k_r[0] <= div_cl.val;
          if (!div_sel_r || !ONE_DIM) sat_r <= sat_r | div_cl.sat;
          div_sel_r <= 1'b1;
          if (div_sel_r || ONE_DIM) pc_r <= PC_CORR;
        end
        ST_FINISH: begin
          if (finish_fire) begin
            out_e0_r <= x_r[0];
            out_e1_r <= ONE_DIM ? '0 : x_r[1];
            out_nc_r <= skip_r;
            out_sat_r <= sat_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the two-state Kalman filter core, with its own fixed-point predictor.
`timescale 1ns / 1ps
module testbench;
  import kf2s_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint ONE_Q16 = 65536;
  localparam int DUE_DEPTH = 64;

  typedef struct {
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic               no_corr;
    logic               sat;
  } estimate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_measurement = '0;
  logic signed [31:0] in_control = '0;
  logic in_reload = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_estimate_first;
  logic signed [31:0] out_estimate_second;
  logic out_no_correction;
  logic out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  kalman_filter_two_state_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] filt_regs [7];
  longint filt_x [2];
  longint filt_p [4];
  logic step_sat;
  estimate_t due_buf [DUE_DEPTH];
  int due_wr = 0;
  int due_rd = 0;
  int mismatches = 0;
  bit steady = 1'b0;
  int out_hold = 0;

  function automatic longint coef_at(int idx, int pos);
    return longint'($signed(filt_regs[idx][pos*16 +: 16]));
  endfunction

  function automatic longint round_mul(longint a, longint b, int sh);
    longint p;
    p = a * b;
    return (p + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      step_sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      step_sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic estimate_t filter_step(longint z, longint u, bit reload);
    longint xp [2];
    longint t [4];
    longint pp [4];
    longint ph [2];
    longint k [2];
    longint m [4];
    longint s, hx, y, acc;
    estimate_t r;
    step_sat = 1'b0;
    r.no_corr = 1'b0;
    if (reload) begin
      for (int i = 0; i < 2; i++) filt_x[i] = coef_at(REG_INIT_STATE, i) * 256;
      for (int i = 0; i < 4; i++) filt_p[i] = coef_at(REG_INIT_COV, i) * 256;
    end
    for (int i = 0; i < 2; i++) begin
      acc = round_mul(coef_at(REG_CONTROL, i), u, 8);
      for (int j = 0; j < 2; j++) acc += round_mul(coef_at(REG_TRANSITION, i*2+j), filt_x[j], 8);
      xp[i] = clamp32(acc);
    end
    filt_x = xp;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        t[i*2+j] = 0;
        for (int c = 0; c < 2; c++)
          t[i*2+j] += round_mul(coef_at(REG_TRANSITION, i*2+c), filt_p[c*2+j], 8);
      end
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        acc = coef_at(REG_PNOISE, i*2+j) * 256;
        for (int c = 0; c < 2; c++)
          acc += round_mul(t[i*2+c], coef_at(REG_TRANSITION, j*2+c), 8);
        pp[i*2+j] = clamp32(acc);
      end
    filt_p = pp;
    for (int i = 0; i < 2; i++) begin
      ph[i] = 0;
      for (int j = 0; j < 2; j++) ph[i] += round_mul(filt_p[i*2+j], coef_at(REG_MROW, j), 8);
    end
    s = longint'(filt_regs[REG_MNOISE][15:0]) * 256;
    for (int i = 0; i < 2; i++) s += round_mul(coef_at(REG_MROW, i), ph[i], 8);
    if (s <= 0) begin
      r.no_corr = 1'b1;
    end else begin
      hx = 0;
      for (int i = 0; i < 2; i++) begin
        k[i] = clamp32((ph[i] * ONE_Q16) / s);
        hx += round_mul(coef_at(REG_MROW, i), filt_x[i], 8);
      end
      y = clamp32(z - hx);
      for (int i = 0; i < 2; i++) filt_x[i] = clamp32(filt_x[i] + round_mul(k[i], y, 16));
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          m[i*2+j] = clamp32((i == j ? ONE_Q16 : 0) - round_mul(k[i], coef_at(REG_MROW, j), 8));
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++) begin
          acc = 0;
          for (int c = 0; c < 2; c++) acc += round_mul(m[i*2+c], filt_p[c*2+j], 16);
          pp[i*2+j] = clamp32(acc);
        end
      filt_p = pp;
    end
    r.first = filt_x[0][31:0];
    r.second = filt_x[1][31:0];
    r.sat = step_sat;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    estimate_t e;
    if (out_valid && out_ready) begin
      if (due_wr == due_rd) begin
        report("unexpected transfer", 0, 0);
      end else begin
        e = due_buf[due_rd % DUE_DEPTH];
        due_rd++;
        if (out_estimate_first !== e.first) report("estimate_first", out_estimate_first, e.first);
        if (out_estimate_second !== e.second)
          report("estimate_second", out_estimate_second, e.second);
        if (out_no_correction !== e.no_corr)
          report("no_correction", out_no_correction, e.no_corr);
        if (out_saturated !== e.sat) report("saturated", out_saturated, e.sat);
      end
      out_hold = steady ? 0 : $urandom_range(0, 4);
    end
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(logic signed [31:0] z, logic signed [31:0] u, bit reload);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_measurement <= z;
    in_control <= u;
    in_reload <= reload;
    do @(posedge clk); while (!in_ready);
    due_buf[due_wr % DUE_DEPTH] = filter_step(z, u, reload);
    due_wr++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_wr != due_rd) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TRANSITION, REG_PNOISE, REG_INIT_COV: filt_regs[idx] = data;
      REG_CONTROL, REG_MROW, REG_INIT_STATE: filt_regs[idx] = {32'd0, data[31:0]};
      REG_MNOISE: filt_regs[idx] = {48'd0, data[15:0]};
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [63:0] pack4(int e0, int e1, int e2, int e3);
    return {e3[15:0], e2[15:0], e1[15:0], e0[15:0]};
  endfunction

  function automatic logic signed [31:0] rand_signal();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
  endfunction

  task automatic tame_config();
    write_reg(REG_TRANSITION, pack4(256 + $urandom_range(0, 16) - 8, $urandom_range(0, 64),
                                    $urandom_range(0, 16) - 8, 256 + $urandom_range(0, 16) - 8));
    write_reg(REG_CONTROL, pack4($urandom_range(0, 128) - 64, $urandom_range(0, 128) - 64, 0, 0));
    write_reg(REG_PNOISE, pack4($urandom_range(0, 64), $urandom_range(0, 8), $urandom_range(0, 8),
                                $urandom_range(0, 64)));
    write_reg(REG_MROW, pack4($urandom_range(0, 512) - 256, $urandom_range(0, 512) - 256, 0, 0));
    write_reg(REG_MNOISE, 64'($urandom_range(0, 1024)));
    write_reg(REG_INIT_STATE, {$urandom, $urandom});
    write_reg(REG_INIT_COV, pack4($urandom_range(0, 1024), 0, 0, $urandom_range(0, 1024)));
  endtask

  task automatic test_defaults();
    send_item(32'sd0, 32'sd0, 1'b0);
    send_item(32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 32'sh80000000, 1'b0);
    send_item(32'sh7fffffff, 32'sh80000000, 1'b1);
    send_item(32'sd65536, -32'sd65536, 1'b0);
    send_item(32'hffffffff, 32'd1, 1'b1);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_UNUSED, '1);
    write_reg(REG_TRANSITION, pack4(32'h7fff, 32'h8000, 32'h7fff, 32'h7fff));
    write_reg(REG_CONTROL, 64'hffffffff_7fff8000);
    write_reg(REG_PNOISE, '1);
    write_reg(REG_MROW, 64'h00000000_80007fff);
    write_reg(REG_MNOISE, 64'hffff);
    write_reg(REG_INIT_STATE, 64'h00000000_80007fff);
    write_reg(REG_INIT_COV, pack4(32'h7fff, 32'h8000, 32'h8000, 32'h7fff));
    send_item(32'sh7fffffff, 32'sh7fffffff, 1'b1);
    send_item(32'sh80000000, 32'sh80000000, 1'b0);
    send_item(32'sd0, 32'sd12345, 1'b0);
    drain();
    // A zero measurement row with zero noise leaves no innovation variance.
    write_reg(REG_TRANSITION, pack4(256, 0, 0, 256));
    write_reg(REG_MROW, '0);
    write_reg(REG_MNOISE, '0);
    write_reg(REG_PNOISE, '0);
    write_reg(REG_CONTROL, pack4(256, 128, 0, 0));
    send_item(32'sd100, 32'sd65536, 1'b1);
    send_item(32'sd100, -32'sd65536, 1'b0);
    drain();
    // A negative covariance makes the innovation variance negative.
    write_reg(REG_MROW, pack4(256, 0, 0, 0));
    write_reg(REG_INIT_COV, pack4(-512, 0, 0, -512));
    send_item(32'sd5000, 32'sd0, 1'b1);
    drain();
    write_reg(REG_MNOISE, '0);
    write_reg(REG_INIT_COV, '0);
    send_item(32'sd5000, 32'sd0, 1'b1);
    drain();
    write_reg(REG_TRANSITION, '0);
    write_reg(REG_CONTROL, '0);
    write_reg(REG_PNOISE, '0);
    write_reg(REG_MROW, '0);
    write_reg(REG_MNOISE, '0);
    write_reg(REG_INIT_STATE, '0);
    write_reg(REG_INIT_COV, '0);
    send_item(32'sd1, 32'sd1, 1'b1);
    drain();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 12; phase++) begin
      if (phase % 4 == 3) begin
        for (int r = 0; r < 7; r++) write_reg(CFG_IDX_W'(r), {$urandom, $urandom});
      end else begin
        tame_config();
      end
      steady = (phase == 5);
      for (int n = 0; n < 128; n++) begin
        send_item(rand_signal(), ($urandom_range(0, 3) == 0) ? 32'sd0 : rand_signal(),
                  n == 0 || $urandom_range(0, 15) == 0);
        if (n == 64 && phase == 2) begin
          in_valid <= 1'b0;
          while (due_wr != due_rd) @(posedge clk);
        end
      end
      drain();
      steady = 1'b0;
    end
  endtask

  initial begin
    foreach (filt_regs[i]) filt_regs[i] = '0;
    filt_regs[REG_TRANSITION] = 64'h0100000000000100;
    filt_regs[REG_MROW] = 64'h100;
    filt_regs[REG_MNOISE] = 64'h100;
    filt_regs[REG_INIT_COV] = 64'h0100000000000100;
    filt_x = '{0, 0};
    filt_p = '{ONE_Q16, 0, 0, ONE_Q16};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_register_extremes();
    test_random_phases();
    drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && due_wr == due_rd) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
